// ===== src/value_occurrence_histogram_macros.svh =====
// Assertion helpers shared by the histogram RTL.
`ifndef VALUE_OCCURRENCE_HISTOGRAM_MACROS_SVH
`define VALUE_OCCURRENCE_HISTOGRAM_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VOH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define VOH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/voh_pkg.sv =====
package voh_pkg;

  localparam int TABLE_DEPTH  = 1024;
  localparam int DISTINCT_MAX = 64;
  localparam int COUNT_BITS   = 16;

  localparam int VALUE_W = 10;
  localparam int OCC_W   = 16;

  localparam int TableAw = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ListAw  = (DISTINCT_MAX > 1) ? $clog2(DISTINCT_MAX) : 1;
  localparam int TotalW  = $clog2(DISTINCT_MAX + 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [VALUE_W-1:0]    value_t;

  localparam count_t COUNT_CAP = '1;

  // Saturate a table count to the width of the result field.
  function automatic logic [OCC_W-1:0] clamp_occ(input count_t cnt);
    logic [31:0] wide;
    wide = 32'(cnt);
    if (wide > 32'(2 ** OCC_W - 1)) begin
      return '1;
    end
    return wide[OCC_W-1:0];
  endfunction

endpackage

// ===== src/voh_ram.sv =====
module voh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Read returns the old word when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/value_occurrence_histogram.sv =====
// Value occurrence histogram.
// Input channel (in_valid_i / in_ready_o): one value per beat, last_item_i
// marks the final value of a set. Values load back to back, one beat per
// cycle; each beat is one read-modify-write of the count table, with the
// previous write forwarded when the same value arrives twice in a row.
// Output channel (out_valid_o / out_ready_i): after the last beat of a set
// the block emits one beat per distinct value, in order of first appearance,
// with its count, a last_result_o mark on the final beat and the overflow
// flag. After the last input beat a finish step runs; each result then
// passes list read, table read and output load in turn, set by the two
// registered memory reads in series. A set with no listed value emits
// nothing. While a set is emitted, the input is not ready.
// Each emitted entry is zeroed in the table as it goes out. A set that
// overflowed the distinct list leaves unlisted counts behind, so the block
// then sweeps the whole table before it takes input. Reset runs the same
// sweep. A stalled receiver holds the output register; the next set still
// loads, and its emission waits.
`include "value_occurrence_histogram_macros.svh"

module value_occurrence_histogram (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  voh_pkg::value_t       value_i,
  input  logic                  last_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output voh_pkg::value_t       distinct_value_o,
  output logic [voh_pkg::OCC_W-1:0] occurrences_o,
  output logic                  last_result_o,
  output logic                  list_overflow_o
);
  import voh_pkg::*;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_LOAD    = 3'd1;
  localparam logic [2:0] ST_FINISH  = 3'd2;
  localparam logic [2:0] ST_EM_LIST = 3'd3;
  localparam logic [2:0] ST_EM_TAB  = 3'd4;
  localparam logic [2:0] ST_EM_OUT  = 3'd5;

  logic [2:0] state_q, state_d;

  // count table and distinct list ports
  logic               tab_we;
  logic [TableAw-1:0] tab_waddr, tab_raddr;
  count_t             tab_wdata, tab_rdata;
  logic               list_we;
  logic [ListAw-1:0]  list_waddr;
  value_t             list_rdata;

  // load stage: the beat whose table word arrives this cycle
  logic               s1_valid_q;
  logic               s1_last_q;
  logic               s1_in_range_q;
  logic [TableAw-1:0] s1_addr_q;
  value_t             s1_value_q;

  // last table write, for forwarding
  logic               prev_valid_q;
  logic [TableAw-1:0] prev_addr_q;
  count_t             prev_data_q;

  logic [TotalW-1:0]  total_q, total_d;
  logic               overflow_q, overflow_d;

  logic [TableAw-1:0] clr_ptr_q, clr_ptr_d;
  logic [ListAw-1:0]  em_k_q, em_k_d;
  logic [TableAw-1:0] em_addr_q;
  value_t             em_dv_q;

  logic               out_valid_q, out_valid_d;
  value_t             out_dv_q;
  logic [OCC_W-1:0]   out_occ_q;
  logic               out_last_q;
  logic               out_ovf_q;

  logic               in_fire;
  logic               in_range;
  logic               s1_write;
  count_t             cur_cnt;
  count_t             new_cnt;
  logic               first_seen;
  logic               em_is_last;
  logic               out_free;

  assign in_ready_o = (state_q == ST_LOAD) && !(s1_valid_q && s1_last_q);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = 32'(value_i) < TABLE_DEPTH;

  // Merge the write from the previous cycle, which the read did not see.
  assign cur_cnt    = (prev_valid_q && (prev_addr_q == s1_addr_q)) ? prev_data_q : tab_rdata;
  assign new_cnt    = (cur_cnt == COUNT_CAP) ? cur_cnt : cur_cnt + count_t'(1);
  assign first_seen = (cur_cnt == '0);
  assign s1_write   = s1_valid_q && s1_in_range_q;

  assign em_is_last = (TotalW'(em_k_q) + TotalW'(1)) == total_q;
  assign out_free   = !out_valid_q || out_ready_i;

  voh_ram #(
    .Width (COUNT_BITS),
    .Depth (TABLE_DEPTH)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (tab_waddr),
    .wdata_i (tab_wdata),
    .raddr_i (tab_raddr),
    .rdata_o (tab_rdata)
  );

  voh_ram #(
    .Width (VALUE_W),
    .Depth (DISTINCT_MAX)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (s1_value_q),
    .raddr_i (em_k_q),
    .rdata_o (list_rdata)
  );

  // Table port selection: sweep, emission zeroing, or load write-back.
  always_comb begin
    tab_raddr = (state_q == ST_EM_TAB) ? TableAw'(list_rdata) : TableAw'(value_i);
    priority if (state_q == ST_CLEAR) begin
      tab_we    = 1'b1;
      tab_waddr = clr_ptr_q;
      tab_wdata = '0;
    end else if (state_q == ST_EM_OUT) begin
      tab_we    = 1'b1;
      tab_waddr = em_addr_q;
      tab_wdata = '0;
    end else begin
      tab_we    = s1_write;
      tab_waddr = s1_addr_q;
      tab_wdata = new_cnt;
    end
  end

  // Append a first occurrence while the list has room.
  always_comb begin
    list_we    = s1_write && first_seen && (total_q < TotalW'(DISTINCT_MAX));
    list_waddr = total_q[ListAw-1:0];
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    overflow_d  = overflow_q;
    clr_ptr_d   = clr_ptr_q;
    em_k_d      = em_k_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (s1_write && first_seen) begin
      if (total_q < TotalW'(DISTINCT_MAX)) begin
        total_d = total_q + TotalW'(1);
      end else begin
        overflow_d = 1'b1;
      end
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_ptr_d = clr_ptr_q + TableAw'(1);
        if (clr_ptr_q == TableAw'(TABLE_DEPTH - 1)) begin
          clr_ptr_d = '0;
          state_d   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (s1_valid_q && s1_last_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        em_k_d = '0;
        if (total_q != '0) begin
          state_d = ST_EM_LIST;
        end else begin
          overflow_d = 1'b0;
          state_d    = ST_LOAD;
        end
      end
      ST_EM_LIST: begin
        // Start the next entry only once the output register will be free.
        if (out_free) begin
          state_d = ST_EM_TAB;
        end
      end
      ST_EM_TAB: begin
        state_d = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        out_valid_d = 1'b1;
        if (em_is_last) begin
          total_d    = '0;
          overflow_d = 1'b0;
          state_d    = overflow_q ? ST_CLEAR : ST_LOAD;
        end else begin
          em_k_d  = em_k_q + ListAw'(1);
          state_d = ST_EM_LIST;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      total_q      <= '0;
      overflow_q   <= 1'b0;
      clr_ptr_q    <= '0;
      em_k_q       <= '0;
      s1_valid_q   <= 1'b0;
      prev_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      total_q      <= total_d;
      overflow_q   <= overflow_d;
      clr_ptr_q    <= clr_ptr_d;
      em_k_q       <= em_k_d;
      s1_valid_q   <= in_fire;
      prev_valid_q <= s1_write;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_last_q     <= last_item_i;
      s1_in_range_q <= in_range;
      s1_addr_q     <= TableAw'(value_i);
      s1_value_q    <= value_i;
    end
    prev_addr_q <= s1_addr_q;
    prev_data_q <= new_cnt;
    if (state_q == ST_EM_TAB) begin
      em_dv_q   <= list_rdata;
      em_addr_q <= TableAw'(list_rdata);
    end
    if (state_q == ST_EM_OUT) begin
      out_dv_q   <= em_dv_q;
      out_occ_q  <= clamp_occ(tab_rdata);
      out_last_q <= em_is_last;
      out_ovf_q  <= overflow_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distinct_value_o = out_dv_q;
  assign occurrences_o    = out_occ_q;
  assign last_result_o    = out_last_q;
  assign list_overflow_o  = out_ovf_q;

  `VOH_ASSERT(a_out_load_from_emit, $rose(out_valid_q) |-> $past(state_q == ST_EM_OUT), "result loaded outside emission")
  `VOH_ASSERT(a_total_bound, total_q <= TotalW'(DISTINCT_MAX), "distinct total beyond list size")
  `VOH_ASSERT(a_overflow_full, overflow_q |-> (total_q == TotalW'(DISTINCT_MAX)), "overflow with list not full")
  `VOH_ASSERT(a_last_to_finish, (s1_valid_q && s1_last_q) |=> (state_q == ST_FINISH), "last beat did not end the set")
  `VOH_ASSERT_ALWAYS(a_no_load_in_sweep, (state_q == ST_CLEAR) |-> !s1_valid_q, "load write during table sweep")

endmodule
